// ===== hdl/fplq_pkg.sv =====
// ----------------------------------------------------------------------------
// fplq_pkg
// Shared constants and types for the fuel priority landing queue: queue
// depth, count width, action codes and the controller command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fplq_pkg;

    // Queue depth and the width of a count that can hold the depth itself
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // Action codes carried by an input beat
    typedef enum logic [1:0] {
        ACT_APPEND   = 2'd0,
        ACT_PRIORITY = 2'd1,
        ACT_REMOVE   = 2'd2
    } action_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the incoming beat
        logic exec;   // apply the captured command to the queue
    } ctrl_cmd_t;

endpackage : fplq_pkg

`default_nettype wire

// ===== hdl/fplq_ctrl.sv =====
// ----------------------------------------------------------------------------
// fplq_ctrl
// Controller for the landing queue: accepts a command beat, runs the execute
// state of the datapath and strobes the result beat afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module fplq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    output logic                    done,
    output fplq_pkg::ctrl_cmd_t     cmd
);

    fplq_pkg::state_t state_reg;
    fplq_pkg::state_t state_next;
    logic             done_reg;
    logic             done_next;

    // Hold state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fplq_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        busy       = 1'b0;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            fplq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = fplq_pkg::ST_EXEC;
                end
            end
            fplq_pkg::ST_EXEC:
            begin
                busy       = 1'b1;
                cmd.exec   = 1'b1;
                done_next  = 1'b1;
                state_next = fplq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fplq_pkg::ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule : fplq_ctrl

`default_nettype wire

// ===== hdl/fplq_datapath.sv =====
// ----------------------------------------------------------------------------
// fplq_datapath
// Shift-register queue of aircraft entries. Every cell compares its fuel
// against the new entry at once; cells then hold, shift back or take the new
// entry. Removal shifts all cells one place forward.
// ----------------------------------------------------------------------------
`default_nettype none

module fplq_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  fplq_pkg::ctrl_cmd_t                cmd,
    input  wire logic [1:0]                    action,
    input  wire logic [15:0]                   aircraft_code,
    input  wire logic [15:0]                   fuel_level,
    output logic                               success,
    output logic [15:0]                        removed_code,
    output logic [15:0]                        removed_fuel,
    output logic [fplq_pkg::CNT_W-1:0]         entry_count
);

    localparam int D = fplq_pkg::QUEUE_DEPTH;
    localparam int W = fplq_pkg::CNT_W;

    // Captured command beat
    logic [1:0]  act_reg;
    logic [15:0] code_in_reg;
    logic [15:0] fuel_in_reg;

    // Queue cells and count
    logic [15:0] code_reg [D];
    logic [15:0] fuel_reg [D];
    logic [15:0] code_next [D];
    logic [15:0] fuel_next [D];
    logic [W-1:0] count_reg;
    logic [W-1:0] count_next;

    // Result registers
    logic         success_reg;
    logic         success_next;
    logic [15:0]  rcode_reg;
    logic [15:0]  rcode_next;
    logic [15:0]  rfuel_reg;
    logic [15:0]  rfuel_next;

    // Cell comparison and insertion values
    logic [D-1:0] lower;
    logic [D-1:0] keep;
    logic [D-1:0] prev_keep;
    logic [15:0]  ins_code [D];
    logic [15:0]  ins_fuel [D];
    logic [15:0]  rem_code [D];
    logic [15:0]  rem_fuel [D];
    logic         is_append;
    logic         full;

    assign is_append = (act_reg == fplq_pkg::ACT_APPEND);
    assign full      = (count_reg == W'(D));

    // Capture the command beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= action;
            code_in_reg <= aircraft_code;
            fuel_in_reg <= fuel_level;
        end
    end

    // Compare every held cell with the new entry
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            lower[i] = (W'(i) < count_reg) &&
                       (is_append || (fuel_reg[i] < fuel_in_reg));
        end
    end

    // A cell stays only if it and all cells ahead of it sort before the new one
    always_comb
    begin
        logic [D-1:0] m;
        for (int i = 0; i < D; i++)
        begin
            m       = (D'(2) << i) - D'(1);
            keep[i] = &(lower | ~m);
        end
        prev_keep = {keep[D-2:0], 1'b1};
    end

    // Work out insert and remove values of each cell
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            if (keep[i])
            begin
                ins_code[i] = code_reg[i];
                ins_fuel[i] = fuel_reg[i];
            end
            else if (prev_keep[i])
            begin
                ins_code[i] = code_in_reg;
                ins_fuel[i] = fuel_in_reg;
            end
            else
            begin
                ins_code[i] = code_reg[(i + D - 1) % D];
                ins_fuel[i] = fuel_reg[(i + D - 1) % D];
            end
        end
        for (int i = 0; i < D - 1; i++)
        begin
            rem_code[i] = code_reg[i + 1];
            rem_fuel[i] = fuel_reg[i + 1];
        end
        rem_code[D-1] = code_reg[D-1];
        rem_fuel[D-1] = fuel_reg[D-1];
    end

    // Decode the action and form next queue and result
    always_comb
    begin
        code_next    = code_reg;
        fuel_next    = fuel_reg;
        count_next   = count_reg;
        success_next = success_reg;
        rcode_next   = rcode_reg;
        rfuel_next   = rfuel_reg;
        if (cmd.exec)
        begin
            success_next = 1'b0;
            rcode_next   = '0;
            rfuel_next   = '0;
            unique case (act_reg) inside
                fplq_pkg::ACT_APPEND,
                fplq_pkg::ACT_PRIORITY:
                begin
                    if (!full)
                    begin
                        code_next    = ins_code;
                        fuel_next    = ins_fuel;
                        count_next   = count_reg + W'(1);
                        success_next = 1'b1;
                    end
                end
                fplq_pkg::ACT_REMOVE:
                begin
                    if (count_reg != '0)
                    begin
                        code_next    = rem_code;
                        fuel_next    = rem_fuel;
                        rcode_next   = code_reg[0];
                        rfuel_next   = fuel_reg[0];
                        count_next   = count_reg - W'(1);
                        success_next = 1'b1;
                    end
                end
                default:
                begin
                    success_next = 1'b0;
                end
            endcase
        end
    end

    // Advance queue cells
    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        fuel_reg  <= fuel_next;
        rcode_reg <= rcode_next;
        rfuel_reg <= rfuel_next;
    end

    // Hold count and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            success_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            success_reg <= success_next;
        end
    end

    assign success      = success_reg;
    assign removed_code = rcode_reg;
    assign removed_fuel = rfuel_reg;
    assign entry_count  = count_reg;

endmodule : fplq_datapath

`default_nettype wire

// ===== hdl/fuel_priority_landing_queue.sv =====
// ----------------------------------------------------------------------------
// fuel_priority_landing_queue
// Bounded landing queue of aircraft entries with tail append, fuel priority
// insert and head removal.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive action, aircraft_code and fuel_level with start
//   high; the beat is taken at a rising edge where start is high and busy is
//   low. Result channel: done is high for exactly one cycle with success,
//   removed_code, removed_fuel and entry_count valid in that cycle.
//   Sequencing: busy is high in the execute state that follows the command
//   edge; done is registered and is high in the cycle after execute.
//   Commands: a new command is not taken while the controller executes the
//   last one and busy is high; a new command may be given in the same cycle
//   as done.
//   Execution compares all queue cells against the new fuel in parallel and
//   shifts the queue within the execute state.
//   Reset: rst_n clears the entry count and the controller; cell contents
//   are left as they are and never read before being written.
//   The receiver cannot stall: each result beat is shown once and not held.
// ----------------------------------------------------------------------------
`default_nettype none

module fuel_priority_landing_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    action,
    input  wire logic [15:0]                   aircraft_code,
    input  wire logic [15:0]                   fuel_level,
    output logic                               done,
    output logic                               success,
    output logic [15:0]                        removed_code,
    output logic [15:0]                        removed_fuel,
    output logic [fplq_pkg::CNT_W-1:0]         entry_count
);

    fplq_pkg::ctrl_cmd_t cmd;

    // Controller
    fplq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Queue datapath
    fplq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .aircraft_code (aircraft_code),
        .fuel_level    (fuel_level),
        .success       (success),
        .removed_code  (removed_code),
        .removed_fuel  (removed_fuel),
        .entry_count   (entry_count)
    );

endmodule : fuel_priority_landing_queue

`default_nettype wire

// ===== hdl/fplq_checker.sv =====
// ----------------------------------------------------------------------------
// fplq_checker
// Port-level checks for the landing queue: command and result sequencing,
// cleared removal fields on failure and the count bound.
// ----------------------------------------------------------------------------
`default_nettype none

module fplq_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire logic                          done,
    input  wire logic                          success,
    input  wire logic [15:0]                   removed_code,
    input  wire logic [15:0]                   removed_fuel,
    input  wire logic [fplq_pkg::CNT_W-1:0]    entry_count
);

    // An accepted beat goes to execute next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat not executed");

    // Execute is followed in the next cycle by the result beat, with busy low
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("execute not followed by result beat");

    // A result beat only follows an execute cycle
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without execute");

    // Failed results carry cleared removal fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !success) |-> (removed_code == 16'd0 && removed_fuel == 16'd0))
        else $error("removal fields set on failure");

    // Count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= fplq_pkg::CNT_W'(fplq_pkg::QUEUE_DEPTH))
        else $error("entry count beyond depth");

endmodule : fplq_checker

bind fuel_priority_landing_queue fplq_checker u_fplq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .success      (success),
    .removed_code (removed_code),
    .removed_fuel (removed_fuel),
    .entry_count  (entry_count)
);

`default_nettype wire

// ===== verif/tb_fuel_priority_landing_queue.sv =====
// ----------------------------------------------------------------------------
// tb_fuel_priority_landing_queue
// Self-checking bench for the fuel priority landing queue. A scoreboard class
// keeps its own copy of the queue, predicts the outcome of every command beat
// that the block takes and checks each done strobe against the oldest
// prediction. A short directed run covers the empty and full queue, fuel
// ties and the extreme field values. It is followed by random runs that are
// biased to fill, drain or churn the queue, with random gaps between beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fuel_priority_landing_queue;

    import fplq_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         MAX_REPORTS  = 40;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_PRIO
    } mix_t;

    typedef struct {
        logic             ok;
        logic [15:0]      code;
        logic [15:0]      fuel;
        logic [CNT_W-1:0] count;
    } landing_outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the queue and the outcomes still to arrive
    // ------------------------------------------------------------------------
    class landing_order_checker;
        logic [15:0]      held_codes [QUEUE_DEPTH];
        logic [15:0]      held_fuels [QUEUE_DEPTH];
        int               held_n;
        landing_outcome_t pending_outcomes [$];
        int               errors;
        int               n_append, n_prio, n_remove, n_unused;
        int               n_full, n_empty, n_ties, peak;

        function new();
            held_n = 0;
            errors = 0;
            n_append = 0; n_prio = 0; n_remove = 0; n_unused = 0;
            n_full = 0; n_empty = 0; n_ties = 0; peak = 0;
        endfunction

        // Open a slot at pos by moving the later entries one place back
        function void place_entry(int pos, logic [15:0] code, logic [15:0] fuel);
            for (int k = held_n; k > pos; k--)
            begin
                held_codes[k] = held_codes[k-1];
                held_fuels[k] = held_fuels[k-1];
            end
            held_codes[pos] = code;
            held_fuels[pos] = fuel;
            held_n++;
            if (held_n > peak)
                peak = held_n;
        endfunction

        // Predict the outcome of one accepted command beat
        function void take_command(logic [1:0] act, logic [15:0] code, logic [15:0] fuel);
            landing_outcome_t res;
            int               pos;
            res.ok    = 1'b0;
            res.code  = '0;
            res.fuel  = '0;
            case (act)
                ACT_APPEND:
                begin
                    n_append++;
                    if (held_n < QUEUE_DEPTH)
                    begin
                        place_entry(held_n, code, fuel);
                        res.ok = 1'b1;
                    end
                    else
                        n_full++;
                end
                ACT_PRIORITY:
                begin
                    n_prio++;
                    if (held_n < QUEUE_DEPTH)
                    begin
                        pos = 0;
                        while (pos < held_n && held_fuels[pos] < fuel)
                            pos++;
                        if (pos < held_n && held_fuels[pos] == fuel)
                            n_ties++;
                        place_entry(pos, code, fuel);
                        res.ok = 1'b1;
                    end
                    else
                        n_full++;
                end
                ACT_REMOVE:
                begin
                    n_remove++;
                    if (held_n > 0)
                    begin
                        res.code = held_codes[0];
                        res.fuel = held_fuels[0];
                        for (int k = 1; k < held_n; k++)
                        begin
                            held_codes[k-1] = held_codes[k];
                            held_fuels[k-1] = held_fuels[k];
                        end
                        held_n--;
                        res.ok = 1'b1;
                    end
                    else
                        n_empty++;
                end
                default:
                    n_unused++;
            endcase
            res.count = held_n[CNT_W-1:0];
            pending_outcomes.push_back(res);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: ERROR %s", $time, msg);
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                note_error($sformatf("%s mismatch: expected 0x%04h, actual 0x%04h",
                                     what, want, got));
        endfunction

        // Check one result beat against the oldest prediction
        function void check_outcome(logic ok, logic [15:0] code, logic [15:0] fuel,
                                    logic [CNT_W-1:0] count);
            landing_outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                note_error("result beat with no command outstanding");
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("success", 16'(want.ok), 16'(ok));
            compare_field("removed_code", want.code, code);
            compare_field("removed_fuel", want.fuel, fuel);
            compare_field("entry_count", 16'(want.count), 16'(count));
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        // Flag any prediction that never got its result
        function void close_out();
            if (pending_outcomes.size() != 0)
                note_error($sformatf("%0d results never arrived", pending_outcomes.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block
    // ------------------------------------------------------------------------
    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             start         = 1'b0;
    logic [1:0]       action        = ACT_APPEND;
    logic [15:0]      aircraft_code = '0;
    logic [15:0]      fuel_level    = '0;
    logic             busy;
    logic             done;
    logic             success;
    logic [15:0]      removed_code;
    logic [15:0]      removed_fuel;
    logic [CNT_W-1:0] entry_count;

    landing_order_checker board = new();
    int                   beats_taken = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fuel_priority_landing_queue i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .aircraft_code (aircraft_code),
        .fuel_level    (fuel_level),
        .done          (done),
        .success       (success),
        .removed_code  (removed_code),
        .removed_fuel  (removed_fuel),
        .entry_count   (entry_count)
    );

    // Note each command beat taken and check each result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                board.take_command(action, aircraft_code, fuel_level);
                beats_taken++;
            end
            if (done)
                board.check_outcome(success, removed_code, removed_fuel, entry_count);
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks, all acting on the falling edge
    // ------------------------------------------------------------------------

    // Hold a command beat until the block takes it
    task automatic issue_command(logic [1:0] act, logic [15:0] code, logic [15:0] fuel);
        int seen;
        seen          = beats_taken;
        start         = 1'b1;
        action        = act;
        aircraft_code = code;
        fuel_level    = fuel;
        do
            @(negedge clk);
        while (beats_taken == seen);
    endtask

    // Drop start for a number of cycles, with junk on the fields
    task automatic idle_for(int cycles);
        for (int i = 0; i < cycles; i++)
        begin
            start         = 1'b0;
            action        = 2'($urandom_range(0, 3));
            aircraft_code = 16'($urandom_range(0, 65535));
            fuel_level    = 16'($urandom_range(0, 65535));
            @(negedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Bias fuel towards a few small values so that ties are common
    function automatic logic [15:0] pick_fuel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, 7));
        else if (r < 70)
            return 16'($urandom_range(0, 255));
        else if (r < 90)
            return 16'($urandom_range(0, 65535));
        return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    function automatic logic [15:0] pick_code();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'h0000;
        else if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [1:0] pick_action(mix_t mix);
        int r;
        int insert_pct;
        r = $urandom_range(0, 99);
        if (r < 3)
            return ACT_UNUSED;
        case (mix)
            MIX_FILL:  insert_pct = 80;
            MIX_DRAIN: insert_pct = 20;
            default:   insert_pct = 50;
        endcase
        if ($urandom_range(0, 99) >= insert_pct)
            return ACT_REMOVE;
        if (mix == MIX_PRIO)
            return ($urandom_range(0, 9) != 0) ? ACT_PRIORITY : ACT_APPEND;
        return ($urandom_range(0, 1) != 0) ? ACT_PRIORITY : ACT_APPEND;
    endfunction

    // Empty and full queue, fuel ties and the extreme field values
    task automatic run_directed();
        issue_command(ACT_REMOVE, 16'hFFFF, 16'hFFFF);
        issue_command(ACT_UNUSED, 16'hA5A5, 16'h5A5A);
        issue_command(ACT_APPEND, 16'h0000, 16'h0000);
        issue_command(ACT_APPEND, 16'hFFFF, 16'hFFFF);
        idle_for(2);
        issue_command(ACT_PRIORITY, 16'h1234, 16'h8000);
        issue_command(ACT_PRIORITY, 16'h2345, 16'hFFFF);
        issue_command(ACT_PRIORITY, 16'h3456, 16'h0000);
        for (int i = 5; i < QUEUE_DEPTH; i++)
        begin
            issue_command(i[0] ? ACT_PRIORITY : ACT_APPEND,
                          16'(i * 16'h1111), 16'((i % 3) * 16'h4000));
            if (i == 9)
                idle_for(1);
        end
        issue_command(ACT_APPEND, 16'hDEAD, 16'h0001);
        issue_command(ACT_PRIORITY, 16'hBEEF, 16'h0000);
        issue_command(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
        issue_command(ACT_REMOVE, 16'h0000, 16'h0000);
        issue_command(ACT_REMOVE, 16'hFFFF, 16'h0000);
        issue_command(ACT_REMOVE, 16'h0000, 16'hFFFF);
    endtask

    // Random runs in segments that fill, drain or churn the queue
    task automatic run_random();
        int         sent;
        int         seg_left;
        bit         quiet;
        mix_t       mix;
        logic [1:0] act;
        sent     = 0;
        seg_left = 0;
        quiet    = 1'b0;
        mix      = MIX_EVEN;
        while (sent < RANDOM_ITEMS)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(10, 40);
                mix      = mix_t'($urandom_range(0, 3));
                quiet    = ($urandom_range(0, 3) == 0);
            end
            seg_left--;
            if (!quiet)
                idle_for(pick_gap());
            act = pick_action(mix);
            issue_command(act, pick_code(), pick_fuel());
            if (act != ACT_UNUSED)
                sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int guard;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        run_random();
        idle_for(1);

        // Wait for the last results, then let the block sit quiet before the close-out
        guard = 0;
        while (board.outstanding() != 0 && guard < 100)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (6) @(negedge clk);
        board.close_out();

        $display("Run covered %0d appends, %0d priority inserts, %0d removals, %0d unused codes",
                 board.n_append, board.n_prio, board.n_remove, board.n_unused);
        $display("with %0d refused when full, %0d when empty, %0d fuel ties, peak depth %0d",
                 board.n_full, board.n_empty, board.n_ties, board.peak);
        if (board.errors == 0)
            $display("** fuel_priority_landing_queue: PASSED **");
        else
            $display("** fuel_priority_landing_queue: FAILED **");
        $finish;
    end

    // Abandon a run that hangs
    initial
    begin
        #5000000;
        $display("%0t ns: ERROR run timed out", $time);
        $display("** fuel_priority_landing_queue: FAILED **");
        $finish;
    end

endmodule : tb_fuel_priority_landing_queue
